// File: hdl/rwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_pkg
// Shared types, widths and register codes of the ring window average block.
// ----------------------------------------------------------------------------
package rwa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WIN_W     = 9;
  localparam int FILLED_W  = 9;
  localparam int QUOT_W    = 16;
  localparam int NUM_WIN   = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WIN_W-1:0]    win_t;
  typedef logic [FILLED_W-1:0] filled_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_WIN_SHORT = 2'd0;
  localparam cfg_idx_t REG_WIN_MID   = 2'd1;
  localparam cfg_idx_t REG_WIN_LONG  = 2'd2;

  // Lane of each window in the per-window arrays.
  localparam int LANE_SHORT = 0;
  localparam int LANE_MID   = 1;
  localparam int LANE_LONG  = 2;

  localparam win_t WIN_SHORT_RST = 9'd12;
  localparam win_t WIN_MID_RST   = 9'd60;
  localparam win_t WIN_LONG_RST  = 9'd180;

endpackage

// File: hdl/rwa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_in_if / rwa_out_if
// Valid/ready channels for the sample beats and the result beats.
// ----------------------------------------------------------------------------
interface rwa_in_if;
  import rwa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rwa_out_if;
  import rwa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t current;
  sample_t avg_short;
  sample_t avg_mid;
  sample_t avg_long;
  filled_t filled;

  modport source (output valid, output current, output avg_short, output avg_mid,
                  output avg_long, output filled, input ready);
  modport sink   (input valid, input current, input avg_short, input avg_mid,
                  input avg_long, input filled, output ready);
endinterface

// File: hdl/rwa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_fifo
// Two-entry queue of job descriptors between the front and the back.
// ----------------------------------------------------------------------------
module rwa_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: hdl/rwa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_front
// Holds the window registers, the write slot and the fill count. Each
// accepted sample becomes a descriptor with its slot, the clamped window
// counts and the oldest slot of each window.
// ----------------------------------------------------------------------------
module rwa_front #(
  parameter int RING_DEPTH = 256,
  parameter int SW         = 8,
  parameter int CW         = 9,
  parameter int DESC_W     = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  rwa_pkg::cfg_idx_t       cfg_index,
  input  rwa_pkg::win_t           cfg_wdata,
  input  logic                    in_valid,
  input  rwa_pkg::sample_t        in_sample,
  output logic                    in_ready,
  output logic                    q_push,
  output logic [DESC_W-1:0]       q_data,
  input  logic                    q_full
);
  import rwa_pkg::*;

  localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;
  localparam int OW   = SW + 2;

  win_t            win_r [NUM_WIN];
  logic [SW-1:0]   slot_r;
  logic [SW-1:0]   slot_nxt;
  logic [CW-1:0]   valid_r;
  logic [CW-1:0]   valid_nxt;
  win_t            weff   [NUM_WIN];
  logic [CW-1:0]   cnt    [NUM_WIN];
  logic [OW-1:0]   old_raw[NUM_WIN];
  logic [SW-1:0]   oldest [NUM_WIN];
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign slot_nxt  = (slot_r == SW'(RING_DEPTH - 1)) ? '0 : slot_r + SW'(1);
  assign valid_nxt = (valid_r < CW'(RING_DEPTH)) ? valid_r + CW'(1) : valid_r;

  // Count per window is min(max(window, 1), samples held after this push);
  // its oldest entry sits count - 1 slots behind the new one.
  always_comb begin
    for (int l = 0; l < NUM_WIN; l++) begin
      weff[l] = (win_r[l] == '0) ? WIN_W'(1) : win_r[l];
      cnt[l]  = (CMPW'(weff[l]) > CMPW'(valid_nxt)) ? valid_nxt : CW'(weff[l]);
      old_raw[l] = OW'(slot_r) + OW'(RING_DEPTH) + OW'(1) - OW'(cnt[l]);
      oldest[l]  = (old_raw[l] >= OW'(RING_DEPTH)) ? SW'(old_raw[l] - OW'(RING_DEPTH))
                                                    : SW'(old_raw[l]);
    end
  end

  assign q_data = {in_sample, slot_r,
                   cnt[LANE_SHORT], cnt[LANE_MID], cnt[LANE_LONG],
                   oldest[LANE_SHORT], oldest[LANE_MID], oldest[LANE_LONG],
                   FILLED_W'(valid_nxt)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[LANE_SHORT] <= WIN_SHORT_RST;
      win_r[LANE_MID]   <= WIN_MID_RST;
      win_r[LANE_LONG]  <= WIN_LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_SHORT: win_r[LANE_SHORT] <= cfg_wdata;
        REG_WIN_MID:   win_r[LANE_MID]   <= cfg_wdata;
        REG_WIN_LONG:  win_r[LANE_LONG]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      valid_r <= '0;
    end else if (accept) begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// File: hdl/rwa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit QUOT_W bits, so the partial remainder starts from the high dividend
// bits and only QUOT_W steps are needed.
// ----------------------------------------------------------------------------
module rwa_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output rwa_pkg::sample_t      quotient
);
  import rwa_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [DIVISOR_W-1:0] div_r;
  logic [QUOT_W-1:0]    qsh_r;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;

  assign trial   = {rem_r, qsh_r[QUOT_W-1]};
  assign qbit    = (trial >= {1'b0, div_r});
  assign rem_nxt = qbit ? DIVISOR_W'(trial - {1'b0, div_r}) : DIVISOR_W'(trial);

  assign done     = done_r;
  assign quotient = qsh_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIVISOR_W'(dividend >> QUOT_W);
      qsh_r <= dividend[QUOT_W-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qsh_r <= {qsh_r[QUOT_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(QUOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// File: hdl/rwa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_back
// Keeps a ring of exclusive prefix sums. Per descriptor it stores the
// running total at the new slot, reads the prefix at each window's oldest
// slot, forms the three window sums and divides them in parallel lanes.
// ----------------------------------------------------------------------------
module rwa_back #(
  parameter int RING_DEPTH = 256,
  parameter int SW         = 8,
  parameter int CW         = 9,
  parameter int DESC_W     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  logic [DESC_W-1:0]  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rwa_pkg::sample_t   out_current,
  output rwa_pkg::sample_t   out_avg_short,
  output rwa_pkg::sample_t   out_avg_mid,
  output rwa_pkg::sample_t   out_avg_long,
  output rwa_pkg::filled_t   out_filled
);
  import rwa_pkg::*;

  // Window sums are at most RING_DEPTH full-scale samples.
  localparam int PSW = SAMPLE_W + SW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_RD2   = 4'd4;
  localparam logic [3:0] S_RD3   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]      state_r;
  logic [3:0]      state_nxt;

  sample_t         d_sample;
  logic [SW-1:0]   d_slot;
  logic [CW-1:0]   d_cnt  [NUM_WIN];
  logic [SW-1:0]   d_old  [NUM_WIN];
  filled_t         d_filled;

  sample_t         sample_r;
  logic [SW-1:0]   slot_r;
  logic [CW-1:0]   cnt_r  [NUM_WIN];
  logic [SW-1:0]   old_r  [NUM_WIN];
  filled_t         filled_r;

  logic [PSW-1:0]  psum_mem_r [RING_DEPTH];
  logic [PSW-1:0]  rd_data_r;
  logic [SW-1:0]   rd_addr;
  logic [PSW-1:0]  total_r;
  logic [PSW-1:0]  sum_r  [NUM_WIN];

  logic            div_start;
  logic [NUM_WIN-1:0] div_done;
  sample_t         quot   [NUM_WIN];

  sample_t         current_r;
  sample_t         avg_r  [NUM_WIN];
  filled_t         filled_out_r;

  assign {d_sample, d_slot,
          d_cnt[LANE_SHORT], d_cnt[LANE_MID], d_cnt[LANE_LONG],
          d_old[LANE_SHORT], d_old[LANE_MID], d_old[LANE_LONG],
          d_filled} = q_data;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign div_start = (state_r == S_DIV);
  assign out_valid = (state_r == S_OUT);

  assign out_current   = current_r;
  assign out_avg_short = avg_r[LANE_SHORT];
  assign out_avg_mid   = avg_r[LANE_MID];
  assign out_avg_long  = avg_r[LANE_LONG];
  assign out_filled    = filled_out_r;

  always_comb begin
    unique case (state_r)
      S_RD0:   rd_addr = old_r[LANE_SHORT];
      S_RD1:   rd_addr = old_r[LANE_MID];
      default: rd_addr = old_r[LANE_LONG];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_RD0;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_RD3;
      S_RD3:   state_nxt = S_DIV;
      S_DIV:   state_nxt = S_WAIT;
      S_WAIT:  if (&div_done) state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WRITE) begin
        total_r <= total_r + PSW'(sample_r);
      end
    end
  end

  // Prefix ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      psum_mem_r[slot_r] <= total_r;
    end
    rd_data_r <= psum_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= d_sample;
      slot_r   <= d_slot;
      filled_r <= d_filled;
      for (int l = 0; l < NUM_WIN; l++) begin
        cnt_r[l] <= d_cnt[l];
        old_r[l] <= d_old[l];
      end
    end
    // total_r already includes the new sample once reads begin.
    unique case (state_r)
      S_RD1:   sum_r[LANE_SHORT] <= total_r - rd_data_r;
      S_RD2:   sum_r[LANE_MID]   <= total_r - rd_data_r;
      S_RD3:   sum_r[LANE_LONG]  <= total_r - rd_data_r;
      default: ;
    endcase
    if ((state_r == S_WAIT) && (&div_done)) begin
      current_r    <= sample_r;
      filled_out_r <= filled_r;
      for (int l = 0; l < NUM_WIN; l++) begin
        avg_r[l] <= quot[l];
      end
    end
  end

  for (genvar g = 0; g < NUM_WIN; g++) begin : g_lane
    rwa_div #(
      .DIVIDEND_W (PSW),
      .DIVISOR_W  (CW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (sum_r[g]),
      .divisor  (cnt_r[g]),
      .done     (div_done[g]),
      .quotient (quot[g])
    );
  end

endmodule

// File: hdl/ring_window_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_window_average_core
// Path: an accepted sample beat passes the two-entry queue and the back's
//   states IDLE, WRITE, RD0 to RD3, DIV, WAIT and OUT to its result beat.
// Throughput: one sample at a time in the back, set by the 16-step divider
//   lanes and the three reads of the single prefix-sum memory port.
// Reset: synchronous, active low; windows return to 12/60/180 and the ring
//   holds no valid entries. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_window_average_core #(
  parameter int RING_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  rwa_pkg::cfg_idx_t cfg_index,
  input  rwa_pkg::win_t     cfg_wdata,
  rwa_in_if.sink            in_if,
  rwa_out_if.source         out_if
);
  import rwa_pkg::*;

  // The front classifies each sample beat: it advances the write slot and the
  // fill count, clamps every window to min(max(window, 1), filled) and finds
  // the oldest slot that each window covers. That descriptor goes into a
  // two-entry queue so new samples are taken while the back is still busy.
  //
  // The back keeps a running total of all samples and, at every slot, the
  // total as it stood before that slot's sample was stored. The sum of a
  // window is then the current total minus the stored prefix at its oldest
  // slot; modular arithmetic over SW + 16 bits keeps this exact even after
  // the total wraps. A window that spans the whole ring still finds its
  // oldest slot intact, since that slot is overwritten only by the next
  // sample. Each sum is divided by its count in its own divider lane.
  localparam int SW     = $clog2(RING_DEPTH);
  localparam int CW     = $clog2(RING_DEPTH + 1);
  localparam int DESC_W = SAMPLE_W + SW + NUM_WIN * CW + NUM_WIN * SW + FILLED_W;

  logic              q_push;
  logic [DESC_W-1:0] q_push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_not_empty;
  logic [DESC_W-1:0] q_pop_data;

  rwa_front #(
    .RING_DEPTH (RING_DEPTH),
    .SW         (SW),
    .CW         (CW),
    .DESC_W     (DESC_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_if.valid),
    .in_sample (in_if.sample),
    .in_ready  (in_if.ready),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  rwa_fifo #(
    .WIDTH (DESC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  // The result registers in the back hold a finished beat while the front
  // keeps taking samples into the queue.
  rwa_back #(
    .RING_DEPTH (RING_DEPTH),
    .SW         (SW),
    .CW         (CW),
    .DESC_W     (DESC_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_current   (out_if.current),
    .out_avg_short (out_if.avg_short),
    .out_avg_mid   (out_if.avg_mid),
    .out_avg_long  (out_if.avg_long),
    .out_filled    (out_if.filled)
  );

endmodule

// File: hdl/rwa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_port_checks
// Port-level checks of the ring window average core, bound to the top.
// ----------------------------------------------------------------------------
module rwa_port_checks #(
  parameter int RING_DEPTH = 256
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input rwa_pkg::sample_t current,
  input rwa_pkg::sample_t avg_short,
  input rwa_pkg::sample_t avg_mid,
  input rwa_pkg::sample_t avg_long,
  input rwa_pkg::filled_t filled
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(current) && $stable(avg_short)
      && $stable(avg_mid) && $stable(avg_long) && $stable(filled))
    else $error("result beat changed while stalled");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // The fill count of a result is never zero and never beyond the ring. A ring
  // deeper than the field can show lets the count wrap, so nothing is checked.
  a_filled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (RING_DEPTH > 511) ||
                  ((filled != '0) && (int'(filled) <= RING_DEPTH)))
    else $error("filled out of range");

  // With one sample held, every average is that sample.
  a_first_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (filled == 9'd1) && (RING_DEPTH < 512) |->
      (avg_short == current) && (avg_mid == current) && (avg_long == current))
    else $error("single-sample averages differ from the sample");

endmodule

bind ring_window_average_core rwa_port_checks #(
  .RING_DEPTH (RING_DEPTH)
) u_rwa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .current   (out_if.current),
  .avg_short (out_if.avg_short),
  .avg_mid   (out_if.avg_mid),
  .avg_long  (out_if.avg_long),
  .filled    (out_if.filled)
);

// File: tb/rwa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_checker
// Watches the sample, result and register ports of the ring window average
// block. It keeps its own copy of the ring and the windows, forms the report
// that each sample beat should produce, and checks every result beat
// against the oldest report still owed.
// ----------------------------------------------------------------------------
module rwa_checker
  import rwa_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  win_t     cfg_wdata,
  rwa_in_if        in_mon,
  rwa_out_if       out_mon,
  output int       pending,
  output int       fail_count
);

  typedef struct packed {
    sample_t current;
    sample_t avg_short;
    sample_t avg_mid;
    sample_t avg_long;
    filled_t filled;
  } load_report_t;

  sample_t      ring_mem [RING_DEPTH];
  int unsigned  head;
  int unsigned  stored;
  win_t         win_len [NUM_WIN];
  load_report_t reports_due [$];
  int unsigned  beat_no;

  initial begin
    fail_count = 0;
    pending    = 0;
    beat_no    = 0;
  end

  task automatic flag(string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  // Floor mean of the newest min(window, stored) samples; a zero window
  // means the newest sample alone.
  function automatic sample_t window_mean(win_t w);
    int unsigned span;
    int unsigned idx;
    int unsigned total;
    span = (w == '0) ? 1 : int'(w);
    if (span > stored) span = stored;
    if (span == 0) return '0;
    total = 0;
    idx   = head;
    for (int unsigned k = 0; k < span; k++) begin
      idx   = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
      total += ring_mem[idx];
    end
    return sample_t'(total / span);
  endfunction

  always @(posedge clk) begin
    load_report_t due;
    load_report_t got;
    if (!rst_n) begin
      head   = 0;
      stored = 0;
      win_len[LANE_SHORT] = WIN_SHORT_RST;
      win_len[LANE_MID]   = WIN_MID_RST;
      win_len[LANE_LONG]  = WIN_LONG_RST;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIN_SHORT: win_len[LANE_SHORT] = cfg_wdata;
          REG_WIN_MID:   win_len[LANE_MID]   = cfg_wdata;
          REG_WIN_LONG:  win_len[LANE_LONG]  = cfg_wdata;
          default: ;
        endcase
      end

      // A result beat always belongs to an older sample, so it is matched
      // before a sample beat on the same edge is folded in.
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.current, out_mon.avg_short, out_mon.avg_mid,
                out_mon.avg_long, out_mon.filled};
        if (reports_due.size() == 0) begin
          flag($sformatf("result beat %0d arrived with nothing outstanding", beat_no));
        end else begin
          due = reports_due.pop_front();
          if (got.current !== due.current)
            flag($sformatf("beat %0d current got %0d want %0d",
                           beat_no, got.current, due.current));
          if (got.avg_short !== due.avg_short)
            flag($sformatf("beat %0d avg_short got %0d want %0d",
                           beat_no, got.avg_short, due.avg_short));
          if (got.avg_mid !== due.avg_mid)
            flag($sformatf("beat %0d avg_mid got %0d want %0d",
                           beat_no, got.avg_mid, due.avg_mid));
          if (got.avg_long !== due.avg_long)
            flag($sformatf("beat %0d avg_long got %0d want %0d",
                           beat_no, got.avg_long, due.avg_long));
          if (got.filled !== due.filled)
            flag($sformatf("beat %0d filled got %0d want %0d",
                           beat_no, got.filled, due.filled));
        end
        beat_no++;
      end

      if (in_mon.valid && in_mon.ready) begin
        ring_mem[head] = in_mon.sample;
        head = (head + 1 >= RING_DEPTH) ? 0 : head + 1;
        if (stored < RING_DEPTH) stored++;
        due.current   = in_mon.sample;
        due.avg_short = window_mean(win_len[LANE_SHORT]);
        due.avg_mid   = window_mean(win_len[LANE_MID]);
        due.avg_long  = window_mean(win_len[LANE_LONG]);
        due.filled    = filled_t'(stored);
        reports_due.push_back(due);
      end
    end
    pending <= reports_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample beats and register writes into ring_window_average_core and
// gives the verdict. A short directed run covers the empty ring, the reset
// windows, a zero window and windows longer than the ring; random phases
// then fill and wrap the ring under changing windows while both sides stall
// at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import rwa_pkg::*;

  localparam int RING_DEPTH   = 256;
  // Index one past the last register; writes to it must change nothing.
  localparam cfg_idx_t REG_UNUSED = 2'd3;
  // Settle a little longer than the block needs for one sample.
  localparam int SETTLE       = 30;
  // Long enough to back the block's internal queue all the way up.
  localparam int HOLD_CYCLES  = 800;
  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 90;
  localparam int DRAIN_LIMIT  = 20000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  win_t     cfg_wdata;
  int       pending;
  int       fail_count;

  // When set, neither side idles. The sample side sets hold_req to ask the
  // result side for one long hold-off.
  bit fast     = 1'b0;
  bit hold_req = 1'b0;

  rwa_in_if  in_ch ();
  rwa_out_if out_ch ();

  ring_window_average_core #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  rwa_checker #(.RING_DEPTH(RING_DEPTH)) load_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #5 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #5ms;
    $display("ring_window_average_core verification failed");
    $finish;
  end

  // Offers one sample beat after a random gap and returns on the edge at
  // which it is taken. With no gap, valid simply stays high from the
  // previous beat.
  task automatic offer_sample(sample_t s);
    int unsigned gap;
    gap = fast ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk iff in_ch.ready);
  endtask

  // Stops offering and waits until every owed result has come back. The
  // first edge lets the checker count the beat that was taken last.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three windows back to back, then one write to the unused
  // index with junk data, which the block has to ignore.
  task automatic program_windows(win_t w_short, win_t w_mid, win_t w_long);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIN_SHORT;
    cfg_wdata <= w_short;
    @(posedge clk);
    cfg_index <= REG_WIN_MID;
    cfg_wdata <= w_mid;
    @(posedge clk);
    cfg_index <= REG_WIN_LONG;
    cfg_wdata <= w_long;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= win_t'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Window lengths lean on the edges: zero, one, the ring size either side,
  // and the largest value the register holds.
  function automatic win_t pick_window();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd2;
      3:       return 9'd255;
      4:       return 9'd256;
      5:       return 9'd257;
      6:       return 9'd511;
      default: return win_t'($urandom_range(0, 511));
    endcase
  endfunction

  // Result side: a random stall before each beat, or one long hold-off when
  // asked. Ready is only lowered on an edge after it was raised.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = fast ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  initial begin : stimulus
    sample_t edge_vals [8];
    sample_t s;
    int      waited;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_WIN_SHORT;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset windows of 12/60/180 against a ring that starts empty, so every
    // average is clipped to the samples stored so far. Full-scale samples
    // next to zero exercise the widest sums and the floor.
    edge_vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001,
                  16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    foreach (edge_vals[i]) offer_sample(edge_vals[i]);
    drain();

    // A zero window must act as one; the other two span the whole ring or reach
    // past it, including the largest register value.
    program_windows('0, 9'd511, 9'd256);
    edge_vals = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE,
                  16'h0000, 16'h1234, 16'hFFFF, 16'h0003};
    foreach (edge_vals[i]) offer_sample(edge_vals[i]);
    drain();

    // Random phases. The ring is never reset again, so it fills up during
    // the first phases and wraps for the rest. Each phase starts from an
    // idle block with new windows.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_windows(9'd1, 9'd256, 9'd511);
        1: program_windows(9'd255, 9'd2, 9'd257);
        default: program_windows(pick_window(), pick_window(), pick_window());
      endcase
      // One phase runs with neither side idling; another holds the result
      // side off long enough that the block stops taking samples.
      fast = (phase == 3);
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(0, 7))
          0:       s = '0;
          1:       s = '1;
          2:       s = sample_t'($urandom_range(0, 15));
          3:       s = sample_t'($urandom_range(16'hFFF0, 16'hFFFF));
          default: s = sample_t'($urandom);
        endcase
        offer_sample(s);
      end
      drain();
      fast = 1'b0;
    end

    // Everything has been offered; wait for the last results, then give any
    // stray beat time to show up before the verdict.
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("ring_window_average_core verification failed");
      $finish;
    end else begin
      repeat (SETTLE) @(posedge clk);
      if (fail_count == 0)
        $display("ring_window_average_core verification clean");
      else
        $display("ring_window_average_core verification failed");
      $finish;
    end
  end

endmodule
